/* design/tms_pkg.sv */
`timescale 1ns / 1ps
package tms_pkg;
    localparam int RulesDef      = 64;
    localparam int TapeCellsDef  = 1024;
    localparam int SymW          = 4;
    localparam int StW           = 8;
    localparam int NstW          = 9;
    localparam int PosW          = 10;
    localparam int IdxW          = 6;
    localparam int CntW          = 7;
    localparam int RuleW         = StW + SymW + NstW + SymW + 1;

    localparam logic [2:0] ACT_ADD    = 3'd0;
    localparam logic [2:0] ACT_REMOVE = 3'd1;
    localparam logic [2:0] ACT_CLEAR  = 3'd2;
    localparam logic [2:0] ACT_LOAD   = 3'd3;
    localparam logic [2:0] ACT_START  = 3'd4;
    localparam logic [2:0] ACT_STEP   = 3'd5;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_HALTED  = 3'd1;
    localparam logic [2:0] ST_NOMATCH = 3'd2;
    localparam logic [2:0] ST_DUP     = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;
    localparam logic [2:0] ST_EDGE    = 3'd5;

    typedef struct packed {
        logic [StW-1:0]  match_state;
        logic [SymW-1:0] match_symbol;
        logic [NstW-1:0] next_state;
        logic [SymW-1:0] write_symbol;
        logic            move_right;
    } t_rule;

    typedef struct packed {
        logic            shift;
        logic            clear;
        logic            load;
        t_rule           ins;
    } t_cell_ctl;
endpackage

/* design/tms_cell.sv */
`timescale 1ns / 1ps
module tms_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tms_pkg::t_cell_ctl    i_ctl,
    input  logic                  i_sel,
    input  tms_pkg::t_rule        i_prev,
    input  logic                  i_prev_vld,
    output tms_pkg::t_rule        o_rule,
    output logic                  o_vld
);
    import tms_pkg::*;
    t_rule r_rule;
    logic  r_vld;

    // shift moves one rule toward the head of the row each cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.clear) begin
            r_vld <= 1'b0;
        end else if (i_ctl.shift && i_sel) begin
            r_vld  <= i_prev_vld;
            r_rule <= i_prev;
        end else if (i_ctl.load && i_sel) begin
            r_vld  <= 1'b1;
            r_rule <= i_ctl.ins;
        end
    end

    assign o_rule = r_rule;
    assign o_vld  = r_vld;
endmodule

/* design/turing_machine_stepper_top.sv */
`timescale 1ns / 1ps
// channel | dir | tdata fields (low bit up)
// s_axis  | in  | action, rule_state, rule_symbol, rule_new_state, rule_new_symbol,
//         |     | rule_move, rule_index, head_position, tape_symbol, tape_first
// m_axis  | out | status, current_state, head_now, last_rule, written_symbol, rule_total
// cfg     | in  | blank_symbol
// every beat passes through the tape read, exec and finish states before the result
// an add, or a step while the machine is not halted, on a nonempty table first rotates the full row
// a remove with an index below the rule count shifts the cells from the index on in the exec cycle
// a load with tape_first clears the loaded bits in a pass over all TAPE_CELLS cells
// reset is synchronous; after reset a pass over all TAPE_CELLS cells clears the loaded bits
// one item at a time; s_axis_tready is low until the result beat is taken
module turing_machine_stepper_top #(
    parameter int RULES      = tms_pkg::RulesDef,
    parameter int TAPE_CELLS = tms_pkg::TapeCellsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata, // action, rule_state, rule_symbol, rule_new_state,
                                      // rule_new_symbol, rule_move, rule_index,
                                      // head_position, tape_symbol, tape_first
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata, // status, current_state, head_now, last_rule,
                                      // written_symbol, rule_total
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata
);
    import tms_pkg::*;

    localparam int RW = $clog2(RULES + 1);
    localparam int TW = $clog2(TAPE_CELLS);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_ROT   = 7'b0000010,
        S_RD    = 7'b0000100,
        S_EXEC  = 7'b0001000,
        S_WIPE  = 7'b0010000,
        S_FIN   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_fsm;

    t_fsm r_fsm;
    logic [55:0] r_in;
    logic [3:0]  r_blank;
    logic [RW-1:0] r_cnt, r_iter;
    logic [NstW-1:0] r_mstate;
    logic [PosW-1:0] r_head;
    logic [6:0]  r_last;
    logic [2:0]  r_status;
    logic [3:0]  r_wsym;
    logic        r_found, r_dup;
    logic [6:0]  r_fidx;
    t_rule       r_frule;
    logic [3:0]  r_sym;
    logic [SymW-1:0] r_tape [TAPE_CELLS];
    logic        r_ld [TAPE_CELLS];
    logic [3:0]  r_rd;
    logic        r_rdl;
    logic [TW:0] r_wipe;

    logic [2:0] w_act;
    t_rule      w_nr;
    logic [IdxW-1:0] w_idx;
    logic [PosW-1:0] w_pos;
    logic [3:0] w_tsym;
    logic       w_first;
    assign w_act   = r_in[2:0];
    assign w_nr    = {r_in[10:3], r_in[14:11], r_in[23:15], r_in[27:24], r_in[28]};
    assign w_idx   = r_in[34:29];
    assign w_pos   = r_in[44:35];
    assign w_tsym  = r_in[48:45];
    assign w_first = r_in[49];

    t_cell_ctl w_ctl;
    t_rule w_rule [RULES];
    logic  w_vld  [RULES];
    logic  w_sel  [RULES];
    logic  w_rot;

    // cell 0 is the head; rotation feeds cell 0 into the tail
    genvar g;
    for (g = 0; g < RULES; g++) begin : g_cell
        t_rule w_p;
        logic  w_pv;
        if (g == RULES - 1) begin : g_tail
            assign w_p  = w_rot ? w_rule[0] : w_rule[g];
            assign w_pv = w_rot ? w_vld[0] : 1'b0;
        end else begin : g_mid
            assign w_p  = w_rule[g+1];
            assign w_pv = w_vld[g+1];
        end
        tms_cell u_cell (
            .i_clk, .i_rst_n, .i_ctl(w_ctl), .i_sel(w_sel[g]),
            .i_prev(w_p), .i_prev_vld(w_pv), .o_rule(w_rule[g]), .o_vld(w_vld[g])
        );
        // rotation moves every cell, remove moves the cells from the index on
        assign w_sel[g] = w_rot ? 1'b1 :
                          (w_act == ACT_REMOVE) ? (RW'(g) >= RW'(w_idx)) :
                          (RW'(g) == r_cnt);
    end

    always_comb begin
        w_ctl = '0;
        w_ctl.ins = w_nr;
        w_rot = (r_fsm == S_ROT);
        if (r_fsm == S_ROT) w_ctl.shift = 1'b1;
        if (r_fsm == S_EXEC && w_act == ACT_REMOVE && RW'(w_idx) < r_cnt)
            w_ctl.shift = 1'b1;
        if (r_fsm == S_EXEC && w_act == ACT_ADD && !r_dup && r_cnt < RW'(RULES))
            w_ctl.load = 1'b1;
        if (r_fsm == S_EXEC && w_act == ACT_CLEAR) w_ctl.clear = 1'b1;
    end

    logic w_head_match, w_head_dup;
    logic [SymW-1:0] w_cur_sym;
    assign w_cur_sym = r_rdl ? r_rd : r_blank;
    assign w_head_match = w_vld[0] && ({1'b0, w_rule[0].match_state} == r_mstate) &&
                          (w_rule[0].match_symbol == r_sym);
    assign w_head_dup   = w_vld[0] && (w_rule[0] == w_nr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blank <= '0;
        end else if (i_cfg_we) begin
            r_blank <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd  <= r_tape[r_head[TW-1:0]];
        r_rdl <= r_ld[r_head[TW-1:0]];
        if (r_fsm == S_WIPE) r_ld[r_wipe[TW-1:0]] <= 1'b0;
        else if (r_fsm == S_FIN && w_act == ACT_LOAD && {22'd0, w_pos} < TAPE_CELLS) begin
            r_tape[w_pos[TW-1:0]] <= w_tsym;
            r_ld[w_pos[TW-1:0]]   <= 1'b1;
        end else if (r_fsm == S_FIN && w_act == ACT_STEP && r_found) begin
            r_tape[r_head[TW-1:0]] <= r_frule.write_symbol;
            r_ld[r_head[TW-1:0]]   <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm <= S_WIPE;
            r_in <= '0;
            r_wipe <= '0;
            r_cnt <= '0;
            r_mstate <= '0;
            r_head <= '0;
            r_last <= 7'h7f;
        end else begin
            case (r_fsm)
                S_IDLE: if (s_axis_tvalid) begin
                    r_in <= s_axis_tdata;
                    r_iter <= '0;
                    r_found <= 1'b0;
                    r_dup <= 1'b0;
                    r_wsym <= '0;
                    r_status <= ST_OK;
                    r_wipe <= '0;
                    r_fsm <= S_RD;
                end
                S_RD: begin
                    r_sym <= w_cur_sym;
                    if ((w_act == ACT_ADD || (w_act == ACT_STEP && !r_mstate[NstW-1]))
                        && r_cnt != '0)
                        r_fsm <= S_ROT;
                    else if (w_act == ACT_LOAD && w_first)
                        r_fsm <= S_WIPE;
                    else
                        r_fsm <= S_EXEC;
                end
                S_ROT: begin
                    if (w_head_match && !r_found && r_iter < r_cnt) begin
                        r_found <= 1'b1;
                        r_fidx  <= 7'(r_iter);
                        r_frule <= w_rule[0];
                    end
                    if (w_head_dup && r_iter < r_cnt) r_dup <= 1'b1;
                    r_iter <= r_iter + 1'b1;
                    if (r_iter == RW'(RULES - 1)) r_fsm <= S_EXEC;
                end
                S_WIPE: begin
                    r_wipe <= r_wipe + 1'b1;
                    // the pass after reset returns to idle
                    if (r_wipe == (TW+1)'(TAPE_CELLS - 1))
                        r_fsm <= (w_act == ACT_LOAD) ? S_EXEC : S_IDLE;
                end
                S_EXEC: begin
                    r_fsm <= S_FIN;
                    case (w_act)
                        ACT_ADD: begin
                            if (r_dup) r_status <= ST_DUP;
                            else if (r_cnt >= RW'(RULES)) r_status <= ST_FULL;
                            else r_cnt <= r_cnt + 1'b1;
                        end
                        ACT_REMOVE: if (RW'(w_idx) < r_cnt) r_cnt <= r_cnt - 1'b1;
                        ACT_CLEAR: begin
                            r_cnt <= '0; r_mstate <= '0; r_head <= '0;
                        end
                        ACT_LOAD: if ({22'd0, w_pos} >= TAPE_CELLS) r_status <= ST_EDGE;
                        ACT_START: begin
                            if ({22'd0, w_pos} < TAPE_CELLS) begin
                                r_mstate <= '0; r_head <= w_pos;
                            end else r_status <= ST_EDGE;
                        end
                        ACT_STEP: begin
                            if (r_mstate[NstW-1]) r_status <= ST_HALTED;
                            else if (!r_found) begin
                                r_last <= 7'h7f; r_status <= ST_NOMATCH;
                            end else begin
                                r_last <= r_fidx;
                                r_mstate <= r_frule.next_state;
                                r_wsym <= r_frule.write_symbol;
                            end
                        end
                        default: ;
                    endcase
                end
                S_FIN: begin
                    r_fsm <= S_OUT;
                    if (w_act == ACT_STEP && r_found) begin
                        if (r_frule.next_state[NstW-1]) r_status <= ST_HALTED;
                        else if (r_frule.move_right) begin
                            if ({22'd0, r_head} + 1 >= TAPE_CELLS) r_status <= ST_EDGE;
                            else r_head <= r_head + 1'b1;
                        end else begin
                            if (r_head == '0) r_status <= ST_EDGE;
                            else r_head <= r_head - 1'b1;
                        end
                    end
                end
                S_OUT: if (m_axis_tready) r_fsm <= S_IDLE;
                default: r_fsm <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_fsm == S_IDLE);
    assign m_axis_tvalid = (r_fsm == S_OUT);
    assign m_axis_tdata = {7'(r_cnt), r_wsym, r_last, r_head, r_mstate, r_status};
endmodule

/* design/tms_checker.sv */
`timescale 1ns / 1ps
module tms_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [39:0] m_axis_tdata
);
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("ready during result");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata)) else $error("unstable");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[39:33] <= 7'd64) else $error("count");
    a_nxt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("busy");
endmodule

bind turing_machine_stepper_top tms_checker u_chk (.*);

/* verif/tb_turing_machine_stepper_top.sv */
`timescale 1ns / 1ps
module tb_turing_machine_stepper_top;
    import tms_pkg::*;

    localparam logic [2:0] ACT_SPARE_A = 3'd6;
    localparam logic [2:0] ACT_SPARE_B = 3'd7;
    localparam int NRULES = RulesDef;
    localparam int NCELLS = TapeCellsDef;
    localparam int STALL_LIMIT = 40000;

    typedef struct {
        logic [2:0]         action;
        logic [7:0]         rstate;
        logic [3:0]         rsym;
        logic signed [8:0]  rnext;
        logic [3:0]         rwrite;
        logic               rmove;
        logic [5:0]         ridx;
        logic [9:0]         pos;
        logic [3:0]         tsym;
        logic               tfirst;
    } t_cmd;

    typedef struct {
        logic [2:0]         status;
        logic signed [8:0]  mstate;
        logic [9:0]         headv;
        logic signed [6:0]  lrule;
        logic [3:0]         wsym;
        logic [6:0]         total;
    } t_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        i_cfg_we = 1'b0;
    logic [3:0]  i_cfg_wdata = '0;

    turing_machine_stepper_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    // machine mirror
    t_rule             rules [NRULES];
    int                rule_cnt;
    logic [3:0]        tape [NCELLS];
    bit                loaded [NCELLS];
    logic signed [8:0] mach_state;
    logic [9:0]        head;
    logic signed [6:0] last_hit;
    logic [3:0]        blank;

    t_res pending_results[$];
    int   err_cnt = 0;
    int   beats_in = 0;
    int   beats_out = 0;
    int   idle_pct = 0;
    int   stall_pct = 0;
    int   quiet_cycles = 0;

    initial forever #5 i_clk = ~i_clk;

    function automatic t_res machine_apply(t_cmd c);
        t_res r;
        t_rule n;
        bit dup;
        int hit;
        logic [3:0] sym;
        r.status = ST_OK;
        r.wsym = '0;
        case (c.action)
            ACT_ADD: begin
                n.match_state = c.rstate;
                n.match_symbol = c.rsym;
                n.next_state = c.rnext;
                n.write_symbol = c.rwrite;
                n.move_right = c.rmove;
                dup = 0;
                for (int i = 0; i < rule_cnt; i++)
                    if (rules[i] == n) dup = 1;
                if (dup) r.status = ST_DUP;
                else if (rule_cnt >= NRULES) r.status = ST_FULL;
                else begin
                    rules[rule_cnt] = n;
                    rule_cnt++;
                end
            end
            ACT_REMOVE: begin
                if (c.ridx < rule_cnt) begin
                    for (int i = c.ridx; i < rule_cnt - 1; i++) rules[i] = rules[i + 1];
                    rule_cnt--;
                end
            end
            ACT_CLEAR: begin
                rule_cnt = 0;
                mach_state = '0;
                head = '0;
            end
            ACT_LOAD: begin
                if (c.tfirst) foreach (loaded[i]) loaded[i] = 0;
                tape[c.pos] = c.tsym;
                loaded[c.pos] = 1;
            end
            ACT_START: begin
                mach_state = '0;
                head = c.pos;
            end
            ACT_STEP: begin
                if (mach_state < 0) r.status = ST_HALTED;
                else begin
                    sym = loaded[head] ? tape[head] : blank;
                    hit = -1;
                    for (int i = 0; i < rule_cnt; i++)
                        if (hit < 0 && $signed({1'b0, rules[i].match_state}) == mach_state
                            && rules[i].match_symbol == sym) hit = i;
                    last_hit = 7'(hit);
                    if (hit < 0) r.status = ST_NOMATCH;
                    else begin
                        mach_state = rules[hit].next_state;
                        tape[head] = rules[hit].write_symbol;
                        loaded[head] = 1;
                        r.wsym = rules[hit].write_symbol;
                        if (mach_state < 0) r.status = ST_HALTED;
                        else if (rules[hit].move_right) begin
                            if (head == NCELLS - 1) r.status = ST_EDGE;
                            else head++;
                        end else begin
                            if (head == 0) r.status = ST_EDGE;
                            else head--;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.mstate = mach_state;
        r.headv = head;
        r.lrule = last_hit;
        r.total = rule_cnt[6:0];
        return r;
    endfunction

    task automatic send_cmd(t_cmd c);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, c.tfirst, c.tsym, c.pos, c.ridx, c.rmove, c.rwrite,
                         c.rnext, c.rsym, c.rstate, c.action};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results = {pending_results, machine_apply(c)};
        beats_in++;
    endtask

    function automatic t_cmd mk(logic [2:0] act);
        t_cmd c;
        c.action = act;
        c.rstate = 8'($urandom);
        c.rsym = 4'($urandom);
        c.rnext = 9'($urandom_range(256) - 1);
        c.rwrite = 4'($urandom);
        c.rmove = 1'($urandom);
        c.ridx = 6'($urandom);
        c.pos = 10'($urandom);
        c.tsym = 4'($urandom);
        c.tfirst = 1'b0;
        return c;
    endfunction

    function automatic t_cmd mk_rule(int st, int sy, int nx, int wr, int mv);
        t_cmd c;
        c = mk(ACT_ADD);
        c.rstate = 8'(st);
        c.rsym = 4'(sy);
        c.rnext = 9'(nx);
        c.rwrite = 4'(wr);
        c.rmove = 1'(mv);
        return c;
    endfunction

    function automatic t_cmd mk_pos(logic [2:0] act, int p, int sy, bit first);
        t_cmd c;
        c = mk(act);
        c.pos = 10'(p);
        c.tsym = 4'(sy);
        c.tfirst = first;
        return c;
    endfunction

    task automatic drain_and_config(int value);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (value >= 0) begin
            i_cfg_we <= 1'b1;
            i_cfg_wdata <= 4'(value);
            @(posedge i_clk);
            i_cfg_we <= 1'b0;
            blank = 4'(value);
            @(posedge i_clk);
        end
    endtask

    task automatic test_rule_edits();
        t_cmd c;
        send_cmd(mk(ACT_CLEAR));
        send_cmd(mk_rule(0, 0, 1, 15, 1));
        send_cmd(mk_rule(255, 15, -1, 0, 0));
        send_cmd(mk_rule(0, 0, 1, 15, 1));
        send_cmd(mk_rule(1, 3, 255, 7, 0));
        c = mk(ACT_REMOVE);
        c.ridx = 6'd63;
        send_cmd(c);
        c.ridx = 6'd0;
        send_cmd(c);
        send_cmd(mk(ACT_SPARE_A));
        send_cmd(mk(ACT_SPARE_B));
        send_cmd(mk(ACT_CLEAR));
    endtask

    task automatic test_full_table();
        for (int i = 0; i < NRULES; i++) send_cmd(mk_rule(i, i % 16, i, i % 16, i % 2));
        send_cmd(mk_rule(200, 1, 2, 3, 0));
        send_cmd(mk_rule(5, 5, 5, 5, 1));
        send_cmd(mk_rule(100, 1, 1, 1, 1));
        send_cmd(mk(ACT_CLEAR));
    endtask

    task automatic test_steps_and_edges();
        send_cmd(mk_pos(ACT_LOAD, 0, 9, 1));
        send_cmd(mk_pos(ACT_LOAD, 1023, 6, 0));
        send_cmd(mk(ACT_STEP));
        send_cmd(mk_rule(0, 9, 0, 4, 0));
        send_cmd(mk_rule(0, 6, 2, 1, 1));
        send_cmd(mk_rule(0, 4, -1, 3, 1));
        send_cmd(mk_pos(ACT_START, 0, 0, 0));
        send_cmd(mk(ACT_STEP));
        send_cmd(mk(ACT_STEP));
        send_cmd(mk(ACT_STEP));
        send_cmd(mk_pos(ACT_START, 1023, 0, 0));
        send_cmd(mk(ACT_STEP));
        send_cmd(mk(ACT_STEP));
        send_cmd(mk_pos(ACT_START, 512, 0, 0));
        send_cmd(mk(ACT_STEP));
    endtask

    // short programs over a few states and symbols, plus full-range noise
    task automatic test_random_programs(int n_items);
        int target;
        int base;
        t_cmd c;
        target = beats_in + n_items;
        while (beats_in < target) begin
            if ($urandom_range(9) == 0) begin
                send_cmd(mk(3'($urandom_range(7))));
                continue;
            end
            send_cmd(mk(ACT_CLEAR));
            base = $urandom_range(1) ? $urandom_range(1023) : ($urandom_range(1) ? 0 : 1023);
            send_cmd(mk_pos(ACT_LOAD, base, $urandom, $urandom_range(3) == 0));
            repeat ($urandom_range(4))
                send_cmd(mk_pos(ACT_LOAD, (base + $urandom_range(6) - 3) & 10'h3ff,
                                $urandom_range(3), 0));
            repeat ($urandom_range(3, 9)) begin
                c = mk_rule($urandom_range(3), $urandom_range(3),
                            $urandom_range(9) == 0 ? -1 : $urandom_range(3),
                            $urandom_range(3), $urandom);
                send_cmd(c);
                if ($urandom_range(5) == 0) send_cmd(c);
            end
            if ($urandom_range(3) == 0) begin
                c = mk(ACT_REMOVE);
                c.ridx = 6'($urandom_range(9));
                send_cmd(c);
            end
            send_cmd(mk_pos(ACT_START, base, 0, 0));
            repeat ($urandom_range(6, 20)) send_cmd(mk(ACT_STEP));
        end
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= (stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        t_res e;
        t_res a;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            beats_out++;
            a.status = m_axis_tdata[2:0];
            a.mstate = m_axis_tdata[11:3];
            a.headv = m_axis_tdata[21:12];
            a.lrule = m_axis_tdata[28:22];
            a.wsym = m_axis_tdata[32:29];
            a.total = m_axis_tdata[39:33];
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected");
                err_cnt++;
            end else begin
                e = pending_results.pop_front();
                if (a.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, a.status); err_cnt++;
                end
                if (a.mstate !== e.mstate) begin
                    $error("current_state exp %0d got %0d", e.mstate, a.mstate); err_cnt++;
                end
                if (a.headv !== e.headv) begin
                    $error("head_now exp %0d got %0d", e.headv, a.headv); err_cnt++;
                end
                if (a.lrule !== e.lrule) begin
                    $error("last_rule exp %0d got %0d", e.lrule, a.lrule); err_cnt++;
                end
                if (a.wsym !== e.wsym) begin
                    $error("written_symbol exp %0d got %0d", e.wsym, a.wsym); err_cnt++;
                end
                if (a.total !== e.total) begin
                    $error("rule_total exp %0d got %0d", e.total, a.total); err_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        rule_cnt = 0;
        mach_state = '0;
        head = '0;
        last_hit = '1;
        blank = '0;
        foreach (loaded[i]) loaded[i] = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_rule_edits();
        test_full_table();
        test_steps_and_edges();
        drain_and_config(15);
        test_steps_and_edges();

        drain_and_config(0);
        test_random_programs(120);
        drain_and_config(15);
        idle_pct = 51;
        test_random_programs(120);
        drain_and_config($urandom_range(15));
        idle_pct = 0;
        stall_pct = 51;
        test_random_programs(120);
        drain_and_config($urandom_range(15));
        idle_pct = 28;
        stall_pct = 28;
        test_random_programs(120);
        drain_and_config(-1);
        repeat (50) @(posedge i_clk);

        $display("covered %0d commands and %0d result beats over four pacing phases",
                 beats_in, beats_out);
        $display("blank symbol swept across 0, 15 and random values");
        if (err_cnt == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

/* files.f */
design/tms_pkg.sv
design/tms_cell.sv
design/turing_machine_stepper_top.sv
design/tms_checker.sv
verif/tb_turing_machine_stepper_top.sv
